// File: design/asc_pkg.sv
// ----------------------------------------------------------------------------
// asc_pkg
// shared types and constants of the aliquot sum classifier
// ----------------------------------------------------------------------------
package asc_pkg;

  // default width of the number to classify
  localparam int NUM_WIDTH_DEF = 16;

  // width of the reported divisor sum, saturating
  localparam int SUM_WIDTH = 18;

  // width of the class code
  localparam int CLASS_WIDTH = 2;

  // result tdata: class and sum packed, padded to whole bytes
  localparam int OUT_TDATA_WIDTH = ((CLASS_WIDTH + SUM_WIDTH + 7) / 8) * 8;

  // class codes
  typedef enum logic [CLASS_WIDTH-1:0] {
    CLASS_DEFICIENT = 2'd0,
    CLASS_PERFECT   = 2'd1,
    CLASS_ABUNDANT  = 2'd2,
    CLASS_INVALID   = 2'd3
  } asc_class_t;

  // request from the sequencer to the remainder unit
  typedef struct packed {
    logic start;
  } asc_div_req_t;

  // status from the remainder unit to the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } asc_div_sts_t;

endpackage

// File: design/asc_divider.sv
// ----------------------------------------------------------------------------
// asc_divider
// restoring serial divider that returns the remainder, one bit per cycle
// ----------------------------------------------------------------------------
module asc_divider #(
  parameter int W = asc_pkg::NUM_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  asc_pkg::asc_div_req_t req,
  input  logic [W-1:0]        dividend,
  input  logic [W-1:0]        divisor,
  output asc_pkg::asc_div_sts_t sts,
  output logic [W-1:0]        remainder
);
  import asc_pkg::*;

  localparam int CW = $clog2(W);
  localparam logic [CW-1:0] CNT_LAST = CW'(W - 1);

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  dvd_r, dvd_nxt;
  logic [W-1:0]  dsr_r, dsr_nxt;
  logic [W:0]    trial;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvd_nxt  = dvd_r;
    dsr_nxt  = dsr_r;
    trial    = {rem_r, dvd_r[W-1]};
    if (req.start && !busy_r) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dvd_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = W'(trial - {1'b0, dsr_r});
      end else begin
        rem_nxt = trial[W-1:0];
      end
      dvd_nxt = {dvd_r[W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    dsr_r <= dsr_nxt;
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign remainder = rem_r;

  // done only ever follows the last step of a running division
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");

  // remainder is below a nonzero divisor at completion
  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (done_r && dsr_r != '0) |-> (rem_r < dsr_r))
    else $error("divider remainder not below divisor");

  // a start while idle always launches a division
  a_start_launches: assert property (@(posedge clk) disable iff (!rst_n)
    (req.start && !busy_r) |=> (busy_r && cnt_r == '0))
    else $error("divider did not start");

endmodule

// File: design/aliquot_sum_classifier_core.sv
// ----------------------------------------------------------------------------
// aliquot_sum_classifier_core
// classifies a number as deficient, perfect or abundant by its aliquot sum
// ----------------------------------------------------------------------------
// usage
//   in_*  : one number per transaction in in_tdata, taken when in_tvalid and
//           in_tready are both high. in_tready is high only while the
//           sequencer is idle, so one number is worked on at a time.
//   out_* : one result per number: class code and saturated divisor sum.
//           out_tvalid holds until out_tready takes the transaction.
// sequencing
//   every trial divisor d from 1 to n-1 goes in turn through the serial
//   remainder unit after a check state, and a divisor that leaves no
//   remainder is added to the sum as the unit reports done; zero and one
//   go straight from the check to the finish. The serial divider sets the
//   run time of a number.
// reset
//   rst_n (synchronous, active low) returns the sequencer to idle and drops
//   out_tvalid; any number in progress is lost.
// stall
//   a waiting result sits in the output register; the next number is taken
//   and worked on meanwhile, and its result waits until the register frees.
// ----------------------------------------------------------------------------
module aliquot_sum_classifier_core #(
  parameter int NUMBER_WIDTH = asc_pkg::NUM_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  // in_tdata: number [NUMBER_WIDTH-1:0]
  input  logic [((NUMBER_WIDTH+7)/8)*8-1:0] in_tdata,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // out_tdata: number_class [1:0], divisor_sum [19:2]
  output logic [asc_pkg::OUT_TDATA_WIDTH-1:0] out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready
);
  import asc_pkg::*;

  // exact sum width: the aliquot sum stays below 16 n for these widths
  localparam int ACC_W = NUMBER_WIDTH + 4;
  localparam int PAD_W = OUT_TDATA_WIDTH - CLASS_WIDTH - SUM_WIDTH;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_CHECK  = 4'b0010,
    S_DIVIDE = 4'b0100,
    S_FINISH = 4'b1000
  } asc_state_t;

  asc_state_t            state_r, state_nxt;
  logic [NUMBER_WIDTH-1:0] held_r, held_nxt;
  logic [NUMBER_WIDTH-1:0] trial_r, trial_nxt;
  logic [ACC_W-1:0]      sum_r, sum_nxt;
  logic                  out_valid_r, out_valid_nxt;
  asc_class_t            out_class_r, out_class_nxt;
  logic [SUM_WIDTH-1:0]  out_sum_r, out_sum_nxt;
  asc_class_t            class_calc;
  logic [SUM_WIDTH-1:0]  sum_sat;
  logic [ACC_W-1:0]      held_ext;
  logic                  in_accept;
  logic                  out_free;
  asc_div_req_t          div_req;
  asc_div_sts_t          div_sts;
  logic [NUMBER_WIDTH-1:0] div_rem;

  // single remainder unit, used for every trial divisor
  asc_divider #(
    .W(NUMBER_WIDTH)
  ) u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .dividend (held_r),
    .divisor  (trial_r),
    .sts      (div_sts),
    .remainder(div_rem)
  );

  // saturate the exact sum to the reported width
  generate
    if (ACC_W > SUM_WIDTH) begin : g_sat
      assign sum_sat = (|sum_r[ACC_W-1:SUM_WIDTH]) ? {SUM_WIDTH{1'b1}}
                                                   : sum_r[SUM_WIDTH-1:0];
    end else begin : g_ext
      assign sum_sat = SUM_WIDTH'(sum_r);
    end
  endgenerate

  // class from the exact sum; a zero number is invalid
  assign held_ext = ACC_W'(held_r);
  always_comb begin
    if (held_r == '0) begin
      class_calc = CLASS_INVALID;
    end else if (sum_r < held_ext) begin
      class_calc = CLASS_DEFICIENT;
    end else if (sum_r == held_ext) begin
      class_calc = CLASS_PERFECT;
    end else begin
      class_calc = CLASS_ABUNDANT;
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  // sequencer: takes a number, steps over the trial divisors and hands out the result
  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    trial_nxt     = trial_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_class_nxt = out_class_r;
    out_sum_nxt   = out_sum_r;
    div_req.start = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          held_nxt  = in_tdata[NUMBER_WIDTH-1:0];
          trial_nxt = NUMBER_WIDTH'(1);
          sum_nxt   = '0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (trial_r < held_r) begin
          div_req.start = 1'b1;
          state_nxt     = S_DIVIDE;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_DIVIDE: begin
        if (div_sts.done) begin
          if (div_rem == '0) begin
            sum_nxt = sum_r + ACC_W'(trial_r);
          end
          trial_nxt = trial_r + 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_class_nxt = class_calc;
          out_sum_nxt   = sum_sat;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and result registers
  always_ff @(posedge clk) begin
    held_r      <= held_nxt;
    trial_r     <= trial_nxt;
    sum_r       <= sum_nxt;
    out_class_r <= out_class_nxt;
    out_sum_r   <= out_sum_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_sum_r, out_class_r};

  // a division is only under way for a proper trial divisor
  a_trial_proper: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIVIDE) |-> (trial_r < held_r && trial_r != '0))
    else $error("trial divisor out of range");

  // the divider only reports back while the sequencer waits for it
  a_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == S_DIVIDE))
    else $error("divider result outside the divide state");

  // a finished item never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FINISH && out_valid_r && !out_tready) |=> (state_r == S_FINISH))
    else $error("result overwritten while stalled");

endmodule
